// ===== rtl/ofu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ofu_pkg;

  // Command codes carried by an input transaction.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_BUS   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // Fetch phase: idle, or waiting for the first, second or third bus byte.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BYTE1 = 2'd1,
    PH_BYTE2 = 2'd2,
    PH_BYTE3 = 2'd3
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_REG  = 2'd0;
  localparam logic [1:0] KIND_REQ  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Register codes.
  localparam logic [3:0] REG_A  = 4'd0;
  localparam logic [3:0] REG_F  = 4'd1;
  localparam logic [3:0] REG_B  = 4'd2;
  localparam logic [3:0] REG_C  = 4'd3;
  localparam logic [3:0] REG_D  = 4'd4;
  localparam logic [3:0] REG_E  = 4'd5;
  localparam logic [3:0] REG_H  = 4'd6;
  localparam logic [3:0] REG_L  = 4'd7;
  localparam logic [3:0] REG_AF = 4'd8;
  localparam logic [3:0] REG_BC = 4'd9;
  localparam logic [3:0] REG_DE = 4'd10;
  localparam logic [3:0] REG_HL = 4'd11;
  localparam logic [3:0] REG_SP = 4'd12;

  // Addressing modes.
  localparam logic [4:0] MODE_IMPLIED   = 5'd0;
  localparam logic [4:0] MODE_IMM8      = 5'd1;
  localparam logic [4:0] MODE_IMM16     = 5'd2;
  localparam logic [4:0] MODE_REG       = 5'd3;
  localparam logic [4:0] MODE_IND_DST   = 5'd4;
  localparam logic [4:0] MODE_IND_SRC   = 5'd5;
  localparam logic [4:0] MODE_IND_RMW   = 5'd6;
  localparam logic [4:0] MODE_IND_IMM8  = 5'd7;
  localparam logic [4:0] MODE_DST_INC   = 5'd8;
  localparam logic [4:0] MODE_DST_DEC   = 5'd9;
  localparam logic [4:0] MODE_SRC_INC   = 5'd10;
  localparam logic [4:0] MODE_SRC_DEC   = 5'd11;
  localparam logic [4:0] MODE_LD_HIGH8  = 5'd12;
  localparam logic [4:0] MODE_LD_ABS16  = 5'd13;
  localparam logic [4:0] MODE_ST_HIGH8  = 5'd14;
  localparam logic [4:0] MODE_ST_ABS16  = 5'd15;
  localparam logic [4:0] MODE_SP_OFS    = 5'd16;
  localparam logic [4:0] MODE_ST_HIGHRD = 5'd17;
  localparam logic [4:0] MODE_LD_HIGHRS = 5'd18;

  localparam logic [7:0]  FLAG_MASK = 8'hF0;
  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  reg_sel;
    logic [15:0] write_value;
    logic [4:0]  addr_mode;
    logic [3:0]  src_reg;
    logic [3:0]  dst_reg;
    logic [15:0] pc_in;
    logic [7:0]  bus_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] reg_value;
    logic [15:0] bus_addr;
    logic [15:0] operand;
    logic [15:0] dest_address;
    logic        dest_in_memory;
    logic [15:0] pc_out;
    logic [1:0]  extra_cycles;
    logic        protocol_error;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/ofu_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ofu_in_if;
  import ofu_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/ofu_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ofu_out_if;
  import ofu_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/cpu_operand_fetch_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Role    Carries
// -------  ------  ----------------------------------------------------------
// req      sink    commands: register write/read, fetch start, bus read data
// rsp      source  one result per command: register answer, bus read
//                  request or fetch done
//
// Every accepted req transaction produces exactly one rsp transaction, held in
// the output register from the next cycle on. One transaction per cycle is
// accepted while rsp does not stall; a single result register holds each result.
// req.ready is high while the output register is empty or is being taken, so a
// stalled rsp holds req off only while its one result is still waiting.
// Synchronous reset clears the register file, SP, the phase and all latches.
module cpu_operand_fetch_unit (
  input  wire          clk,
  input  wire          rst,
  ofu_in_if.sink       req,
  ofu_out_if.source    rsp
);
  import ofu_pkg::*;

  // Architectural registers.
  logic [7:0]  reg_a, reg_f, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l;
  logic [15:0] sp;

  // Fetch state.
  phase_t      phase, phase_next;
  logic [4:0]  mode_latch, mode_next;
  logic [15:0] pc_latch, pc_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [15:0] operand_latch, operand_next;
  logic [15:0] dest_latch, dest_next;
  logic        dest_mem, dest_mem_next;

  // Output register.
  logic        out_valid;
  out_item_t   out_data;

  // Register file write port and the separate flag update of the SP offset mode.
  logic        rf_we;
  logic [3:0]  rf_sel;
  logic [15:0] rf_val;
  logic        flag_we;
  logic [7:0]  flag_val;

  logic        accept;
  out_item_t   res;
  logic [15:0] rs_val, rd_val, sel_val, echo_val;
  logic [7:0]  b;
  logic [15:0] b_ext, sp_sum, sp_carry;
  logic        busy;

  // Per-transaction outcome: finish the fetch, or issue one bus read.
  logic        fin;
  logic [1:0]  fin_extra;
  logic        rq;
  logic [15:0] rq_addr;
  phase_t      rq_phase;

  function automatic logic [15:0] rf_read(input logic [3:0] r);
    logic [15:0] v;
    case (r)
      REG_A:   v = {8'h00, reg_a};
      REG_F:   v = {8'h00, reg_f};
      REG_B:   v = {8'h00, reg_b};
      REG_C:   v = {8'h00, reg_c};
      REG_D:   v = {8'h00, reg_d};
      REG_E:   v = {8'h00, reg_e};
      REG_H:   v = {8'h00, reg_h};
      REG_L:   v = {8'h00, reg_l};
      REG_AF:  v = {reg_a, reg_f};
      REG_BC:  v = {reg_b, reg_c};
      REG_DE:  v = {reg_d, reg_e};
      REG_HL:  v = {reg_h, reg_l};
      default: v = sp;   // SP and the unused codes above it
    endcase
    return v;
  endfunction

  assign accept      = req.valid && req.ready;
  assign req.ready   = !out_valid || rsp.ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  always_comb begin
    rs_val  = rf_read(req.payload.src_reg);
    rd_val  = rf_read(req.payload.dst_reg);
    sel_val = rf_read(req.payload.reg_sel);
  end

  assign b       = req.payload.bus_byte;
  assign busy    = (phase != PH_IDLE);

  // SP plus sign-extended byte; the carry vector gives H from bit 4 and C from bit 8.
  assign b_ext    = {{8{b[7]}}, b};
  assign sp_sum   = sp + b_ext;
  assign sp_carry = sp_sum ^ sp ^ b_ext;

  // Value that reads back after a register write: F keeps its top nibble only.
  always_comb begin
    if (req.payload.reg_sel == REG_F) begin
      echo_val = {8'h00, req.payload.write_value[7:0] & FLAG_MASK};
    end else if (req.payload.reg_sel inside {[REG_A:REG_L]}) begin
      echo_val = {8'h00, req.payload.write_value[7:0]};
    end else if (req.payload.reg_sel == REG_AF) begin
      echo_val = {req.payload.write_value[15:8], req.payload.write_value[7:0] & FLAG_MASK};
    end else begin
      echo_val = req.payload.write_value;
    end
  end

  always_comb begin
    res           = '0;
    phase_next    = phase;
    mode_next     = mode_latch;
    pc_next       = pc_latch;
    low_byte_next = low_byte;
    operand_next  = operand_latch;
    dest_next     = dest_latch;
    dest_mem_next = dest_mem;
    rf_we         = 1'b0;
    rf_sel        = req.payload.reg_sel;
    rf_val        = req.payload.write_value;
    flag_we       = 1'b0;
    flag_val      = {2'b00, sp_carry[4], sp_carry[8], 4'h0};
    fin           = 1'b0;
    fin_extra     = 2'd0;
    rq            = 1'b0;
    rq_addr       = pc_latch;
    rq_phase      = PH_BYTE1;

    if ((req.payload.cmd == CMD_BUS) != busy) begin
      // The command does not fit the phase: report it and change nothing.
      res.kind           = KIND_REG;
      res.protocol_error = 1'b1;
    end else begin
      case (req.payload.cmd)
        CMD_WRITE: begin
          rf_we         = 1'b1;
          res.kind      = KIND_REG;
          res.reg_value = echo_val;
        end
        CMD_READ: begin
          res.kind      = KIND_REG;
          res.reg_value = sel_val;
        end
        CMD_START: begin
          mode_next     = req.payload.addr_mode;
          pc_next       = req.payload.pc_in;
          dest_mem_next = 1'b0;
          case (req.payload.addr_mode)
            MODE_IMM8, MODE_IMM16, MODE_LD_HIGH8, MODE_LD_ABS16, MODE_SP_OFS: begin
              rq      = 1'b1;
              rq_addr = req.payload.pc_in;
              pc_next = req.payload.pc_in + 16'd1;
            end
            MODE_REG: begin
              operand_next = rs_val;
              fin          = 1'b1;
            end
            MODE_IND_DST: begin
              dest_next     = rd_val;
              dest_mem_next = 1'b1;
              operand_next  = rs_val;
              fin           = 1'b1;
            end
            MODE_IND_SRC: begin
              rq      = 1'b1;
              rq_addr = rs_val;
            end
            MODE_IND_RMW: begin
              dest_next     = rs_val;
              dest_mem_next = 1'b1;
              rq            = 1'b1;
              rq_addr       = rs_val;
            end
            MODE_IND_IMM8: begin
              dest_next     = rd_val;
              dest_mem_next = 1'b1;
              rq            = 1'b1;
              rq_addr       = req.payload.pc_in;
              pc_next       = req.payload.pc_in + 16'd1;
            end
            MODE_DST_INC, MODE_DST_DEC: begin
              operand_next  = rs_val;
              dest_next     = rd_val;
              dest_mem_next = 1'b1;
              rf_we         = 1'b1;
              rf_sel        = req.payload.dst_reg;
              rf_val        = (req.payload.addr_mode == MODE_DST_INC) ?
                              rd_val + 16'd1 : rd_val - 16'd1;
              fin           = 1'b1;
            end
            MODE_SRC_INC, MODE_SRC_DEC: begin
              rf_we   = 1'b1;
              rf_sel  = req.payload.src_reg;
              rf_val  = (req.payload.addr_mode == MODE_SRC_INC) ?
                        rs_val + 16'd1 : rs_val - 16'd1;
              rq      = 1'b1;
              rq_addr = rs_val;
            end
            MODE_ST_HIGH8, MODE_ST_ABS16: begin
              operand_next  = rs_val;
              dest_mem_next = 1'b1;
              rq            = 1'b1;
              rq_addr       = req.payload.pc_in;
              pc_next       = req.payload.pc_in + 16'd1;
            end
            MODE_ST_HIGHRD: begin
              operand_next  = rs_val;
              dest_next     = HIGH_PAGE + rd_val;
              dest_mem_next = 1'b1;
              fin           = 1'b1;
            end
            MODE_LD_HIGHRS: begin
              dest_next = HIGH_PAGE + rs_val;
              rq        = 1'b1;
              rq_addr   = HIGH_PAGE + rs_val;
            end
            default: begin
              // Implied and the unused mode codes finish at once.
              fin = 1'b1;
            end
          endcase
        end
        default: begin
          // Bus data while a fetch waits.
          case (phase)
            PH_BYTE1: begin
              case (mode_latch)
                MODE_IMM8, MODE_IND_SRC, MODE_IND_RMW, MODE_IND_IMM8,
                MODE_SRC_INC, MODE_SRC_DEC, MODE_LD_HIGHRS: begin
                  operand_next = {8'h00, b};
                  fin          = 1'b1;
                  fin_extra    = 2'd1;
                end
                MODE_IMM16, MODE_LD_ABS16, MODE_ST_ABS16: begin
                  low_byte_next = b;
                  rq            = 1'b1;
                  rq_addr       = pc_latch;
                  rq_phase      = PH_BYTE2;
                  pc_next       = pc_latch + 16'd1;
                end
                MODE_LD_HIGH8: begin
                  dest_next = HIGH_PAGE + {8'h00, b};
                  rq        = 1'b1;
                  rq_addr   = HIGH_PAGE + {8'h00, b};
                  rq_phase  = PH_BYTE2;
                end
                MODE_ST_HIGH8: begin
                  dest_next = HIGH_PAGE + {8'h00, b};
                  fin       = 1'b1;
                  fin_extra = 2'd1;
                end
                MODE_SP_OFS: begin
                  operand_next = sp_sum;
                  flag_we      = 1'b1;
                  fin          = 1'b1;
                  fin_extra    = 2'd2;
                end
                default: begin
                  fin = 1'b1;
                end
              endcase
            end
            PH_BYTE2: begin
              case (mode_latch)
                MODE_IMM16: begin
                  operand_next = {b, low_byte};
                  fin          = 1'b1;
                  fin_extra    = 2'd2;
                end
                MODE_LD_HIGH8: begin
                  operand_next = {8'h00, b};
                  fin          = 1'b1;
                  fin_extra    = 2'd2;
                end
                MODE_LD_ABS16: begin
                  dest_next = {b, low_byte};
                  rq        = 1'b1;
                  rq_addr   = {b, low_byte};
                  rq_phase  = PH_BYTE3;
                end
                MODE_ST_ABS16: begin
                  dest_next = {b, low_byte};
                  fin       = 1'b1;
                  fin_extra = 2'd2;
                end
                default: begin
                  fin = 1'b1;
                end
              endcase
            end
            default: begin
              // Third byte: only the absolute load reaches this phase.
              fin = 1'b1;
              if (mode_latch == MODE_LD_ABS16) begin
                operand_next = {8'h00, b};
                fin_extra    = 2'd3;
              end
            end
          endcase
        end
      endcase
    end

    if (fin) begin
      phase_next         = PH_IDLE;
      res.kind           = KIND_DONE;
      res.operand        = operand_next;
      res.dest_address   = dest_next;
      res.dest_in_memory = dest_mem_next;
      res.pc_out         = pc_next;
      res.extra_cycles   = fin_extra;
    end
    if (rq) begin
      phase_next   = rq_phase;
      res.kind     = KIND_REQ;
      res.bus_addr = rq_addr;
    end
  end

  // State registers advance only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a         <= 8'h00;
      reg_f         <= 8'h00;
      reg_b         <= 8'h00;
      reg_c         <= 8'h00;
      reg_d         <= 8'h00;
      reg_e         <= 8'h00;
      reg_h         <= 8'h00;
      reg_l         <= 8'h00;
      sp            <= 16'h0000;
      phase         <= PH_IDLE;
      mode_latch    <= 5'd0;
      pc_latch      <= 16'h0000;
      low_byte      <= 8'h00;
      operand_latch <= 16'h0000;
      dest_latch    <= 16'h0000;
      dest_mem      <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      mode_latch    <= mode_next;
      pc_latch      <= pc_next;
      low_byte      <= low_byte_next;
      operand_latch <= operand_next;
      dest_latch    <= dest_next;
      dest_mem      <= dest_mem_next;
      if (rf_we) begin
        case (rf_sel)
          REG_A:   reg_a <= rf_val[7:0];
          REG_F:   reg_f <= rf_val[7:0] & FLAG_MASK;
          REG_B:   reg_b <= rf_val[7:0];
          REG_C:   reg_c <= rf_val[7:0];
          REG_D:   reg_d <= rf_val[7:0];
          REG_E:   reg_e <= rf_val[7:0];
          REG_H:   reg_h <= rf_val[7:0];
          REG_L:   reg_l <= rf_val[7:0];
          REG_AF: begin
            reg_a <= rf_val[15:8];
            reg_f <= rf_val[7:0] & FLAG_MASK;
          end
          REG_BC: begin
            reg_b <= rf_val[15:8];
            reg_c <= rf_val[7:0];
          end
          REG_DE: begin
            reg_d <= rf_val[15:8];
            reg_e <= rf_val[7:0];
          end
          REG_HL: begin
            reg_h <= rf_val[15:8];
            reg_l <= rf_val[7:0];
          end
          default: sp <= rf_val;
        endcase
      end
      if (flag_we) begin
        reg_f <= flag_val;
      end
    end
  end

  // Output register: loads on accept, empties when taken with nothing new.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  // Each accepted transaction leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("accepted transaction produced no result");

  // Bus data while idle is flagged as a protocol error.
  a_idle_bus_error: assert property (@(posedge clk) disable iff (rst)
    (accept && req.payload.cmd == CMD_BUS && phase == PH_IDLE)
      |=> (rsp.valid && rsp.payload.protocol_error))
    else $error("bus data while idle not flagged");

  // A finished fetch returns the phase to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && res.kind == KIND_DONE) |=> (phase == PH_IDLE))
    else $error("fetch done but phase not idle");

  // A bus read request leaves the unit waiting for data.
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && res.kind == KIND_REQ) |=> (phase != PH_IDLE))
    else $error("bus request issued but phase idle");

  // An empty output register never holds off the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> req.ready)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire
